>>> sv/gzhp_pkg.sv
`default_nettype none

package gzhp_pkg;

    // Default width of the byte position counter
    localparam int unsigned POS_BITS_DEF = 23;

    // Widths of the stream fields
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned OFFSET_W = 23;

    // Largest offset that the result can carry
    localparam logic [31:0] OFFSET_MAX = 32'h007F_FFFF;

    // Name limit after reset
    localparam logic [7:0] NAME_LIMIT_RST = 8'd127;

    // Header constants
    localparam logic [7:0] GZ_MAGIC1      = 8'h1F;
    localparam logic [7:0] GZ_MAGIC2      = 8'h8B;
    localparam logic [7:0] GZ_CM_DEFLATE  = 8'd8;
    localparam logic [15:0] GZ_FIXED_LEN  = 16'd6;
    localparam logic [15:0] GZ_HCRC_LEN   = 16'd2;

    // Flag byte bits that drive the parse
    localparam int unsigned FLG_HCRC    = 1;
    localparam int unsigned FLG_EXTRA   = 2;
    localparam int unsigned FLG_NAME    = 3;
    localparam int unsigned FLG_COMMENT = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER     = 3'd0,
        KIND_NAME       = 3'd1,
        KIND_DATA_FIRST = 3'd2,
        KIND_DATA_REST  = 3'd3,
        KIND_ERROR      = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    name_char;
        logic [OFFSET_W-1:0]  comp_offset;
    } result_t;

endpackage

`default_nettype wire

>>> sv/gzhp_parse.sv
`default_nettype none

module gzhp_parse #(
    parameter int unsigned POS_BITS = gzhp_pkg::POS_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 is_first,
    input  wire logic                 is_last,
    input  wire logic [7:0]           name_limit,
    output gzhp_pkg::result_t         result
);
    import gzhp_pkg::*;

    typedef enum logic [3:0] {
        P_MAGIC1     = 4'd0,
        P_MAGIC2     = 4'd1,
        P_METHOD     = 4'd2,
        P_FLAGS      = 4'd3,
        P_FIXED      = 4'd4,
        P_XLEN_LO    = 4'd5,
        P_XLEN_HI    = 4'd6,
        P_EXTRA      = 4'd7,
        P_NAME       = 4'd8,
        P_COMMENT    = 4'd9,
        P_HCRC       = 4'd10,
        P_DATA_FIRST = 4'd11,
        P_DATA_REST  = 4'd12,
        P_ERROR      = 4'd13
    } phase_t;

    phase_t                phase_reg, phase_next, ph_cur;
    logic [POS_BITS-1:0]   pos_reg, pos_next, pos_cur;
    logic [4:0]            flags_reg, flags_next, flags_cur;
    logic [15:0]           skip_reg, skip_next, skip_cur;
    logic [7:0]            xlo_reg, xlo_next, xlo_cur;
    logic [7:0]            ncount_reg, ncount_next, ncount_cur;
    logic [15:0]           xlen;
    logic [31:0]           pos_wide;
    logic                  err;
    kind_t                 kind;
    logic [7:0]            nc;
    logic [OFFSET_W-1:0]   off;

    // Next optional section after the one given
    function automatic phase_t next_section(phase_t from, logic [4:0] flg);
        phase_t nxt;
        nxt = P_DATA_FIRST;
        if (from < P_HCRC && flg[FLG_HCRC])       nxt = P_HCRC;
        if (from < P_COMMENT && flg[FLG_COMMENT]) nxt = P_COMMENT;
        if (from < P_NAME && flg[FLG_NAME])       nxt = P_NAME;
        if (from < P_XLEN_LO && flg[FLG_EXTRA])   nxt = P_XLEN_LO;
        return nxt;
    endfunction

    always_comb begin
        // A first byte restarts from a clean parse
        ph_cur     = is_first ? P_MAGIC1 : phase_reg;
        pos_cur    = is_first ? '0 : pos_reg;
        flags_cur  = is_first ? '0 : flags_reg;
        skip_cur   = is_first ? '0 : skip_reg;
        xlo_cur    = is_first ? '0 : xlo_reg;
        ncount_cur = is_first ? '0 : ncount_reg;

        phase_next  = ph_cur;
        pos_next    = pos_cur;
        flags_next  = flags_cur;
        skip_next   = skip_cur;
        xlo_next    = xlo_cur;
        ncount_next = ncount_cur;

        xlen     = {data_byte, xlo_cur};
        pos_wide = 32'(pos_cur);
        err      = 1'b0;
        kind     = KIND_HEADER;
        nc       = '0;
        off      = '0;

        unique case (ph_cur)
            P_MAGIC1: begin
                if (data_byte != GZ_MAGIC1) err = 1'b1;
                else phase_next = P_MAGIC2;
            end
            P_MAGIC2: begin
                if (data_byte != GZ_MAGIC2) err = 1'b1;
                else phase_next = P_METHOD;
            end
            P_METHOD: begin
                if (data_byte != GZ_CM_DEFLATE) err = 1'b1;
                else phase_next = P_FLAGS;
            end
            P_FLAGS: begin
                flags_next = data_byte[4:0];
                skip_next  = GZ_FIXED_LEN;
                phase_next = P_FIXED;
            end
            P_FIXED, P_EXTRA, P_HCRC: begin
                if (skip_cur <= 16'd1) begin
                    skip_next  = '0;
                    phase_next = (ph_cur == P_HCRC) ? P_DATA_FIRST
                                                    : next_section(ph_cur, flags_cur);
                end else begin
                    skip_next = skip_cur - 16'd1;
                end
            end
            P_XLEN_LO: begin
                xlo_next   = data_byte;
                phase_next = P_XLEN_HI;
            end
            P_XLEN_HI: begin
                skip_next  = xlen;
                phase_next = (xlen == 16'd0) ? next_section(P_EXTRA, flags_cur) : P_EXTRA;
            end
            P_NAME: begin
                if (data_byte == 8'd0) begin
                    phase_next = next_section(P_NAME, flags_cur);
                end else if (ncount_cur < name_limit) begin
                    kind        = KIND_NAME;
                    nc          = data_byte;
                    ncount_next = ncount_cur + 8'd1;
                end
            end
            P_COMMENT: begin
                if (data_byte == 8'd0) phase_next = next_section(P_COMMENT, flags_cur);
            end
            P_DATA_FIRST: begin
                if (pos_wide > OFFSET_MAX || pos_cur == '1) begin
                    err = 1'b1;
                end else begin
                    kind       = KIND_DATA_FIRST;
                    off        = pos_wide[OFFSET_W-1:0];
                    phase_next = P_DATA_REST;
                end
            end
            P_DATA_REST: kind = KIND_DATA_REST;
            default:     err = 1'b1;
        endcase

        // Header CRC span always starts at two bytes
        if (phase_next == P_HCRC && ph_cur != P_HCRC) skip_next = GZ_HCRC_LEN;

        // A last byte inside the header is an error
        if (!err && (kind == KIND_HEADER || kind == KIND_NAME) && is_last) err = 1'b1;

        if (err) begin
            kind       = KIND_ERROR;
            nc         = '0;
            off        = '0;
            phase_next = P_ERROR;
        end

        // Count header bytes, saturate at the counter top
        if (ph_cur < P_DATA_FIRST && pos_cur != '1) pos_next = pos_cur + POS_BITS'(1);

        result.kind        = kind;
        result.name_char   = nc;
        result.comp_offset = off;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= P_MAGIC1;
            pos_reg    <= '0;
            flags_reg  <= '0;
            skip_reg   <= '0;
            xlo_reg    <= '0;
            ncount_reg <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            flags_reg  <= flags_next;
            skip_reg   <= skip_next;
            xlo_reg    <= xlo_next;
            ncount_reg <= ncount_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/gzip_header_parser.sv
// Channel   | Ports                         | Contents
// ----------+-------------------------------+------------------------------------------
// s_ in     | s_tvalid s_tready s_tdata     | tdata: data_byte; tuser: is_first;
//           | s_tuser s_tlast               | tlast: is_last
// m_ out    | m_tvalid m_tready m_tdata     | tdata: name_char, comp_offset, pad;
//           | m_tuser                       | tuser: kind
// cfg       | cfg_wr_en cfg_wr_data         | name_limit
//
// One transaction in, one transaction out; one byte per cycle sustained while the m_ side takes each result.
// Result appears in the cycle after the input transaction: the parse state and
// classification are one combinational step between the state registers and
// the output register.
// Reset (aresetn low at a clock edge) returns the parser to the first magic
// byte and sets name_limit to 127.
// A stalled m_ side holds the result; s_tready drops only while the output
// register is full and not being taken.

`default_nettype none

module gzip_header_parser #(
    parameter int unsigned POS_BITS = gzhp_pkg::POS_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] is_first
    input  wire logic        s_tlast,   // is_last

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] name_char, [30:8] comp_offset, [31] zero
    output logic [2:0]       m_tuser,   // [2:0] kind

    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data // name_limit
);
    import gzhp_pkg::*;

    logic       in_take;
    logic [7:0] name_limit_reg;
    logic       m_valid_reg;
    result_t    res_next;
    result_t    res_reg;

    // Accept whenever the output register is empty or draining this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    gzhp_parse #(
        .POS_BITS (POS_BITS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (in_take),
        .data_byte  (s_tdata),
        .is_first   (s_tuser[0]),
        .is_last    (s_tlast),
        .name_limit (name_limit_reg),
        .result     (res_next)
    );

    // Hold name_limit; the user must write it only while the stream is idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg <= NAME_LIMIT_RST;
        end else if (cfg_wr_en) begin
            name_limit_reg <= cfg_wr_data;
        end
    end

    // Output register: load on an input transaction, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg.comp_offset, res_reg.name_char};
    assign m_tuser  = res_reg.kind;

endmodule

`default_nettype wire

>>> sv/gzhp_checker.sv
`default_nettype none

module gzhp_sva (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);
    import gzhp_pkg::*;

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // Every input transaction produces a result in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after input transaction");

    // An empty output register never back-pressures the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Name byte only carried by name results
    a_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_NAME |-> m_tdata[7:0] == 8'd0)
        else $error("name byte outside name result");

    // Offset only carried by the first compressed byte
    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_DATA_FIRST |-> m_tdata[31:8] == 24'd0)
        else $error("offset outside first data result");

endmodule

bind gzip_header_parser gzhp_sva u_gzhp_sva (.*);

`default_nettype wire
